>>> design/bpf_pkg.sv
`default_nettype none

package bpf_pkg;

  localparam int COORD_WIDTH = 24;

  // Guard bits for the weighted sums: the largest weight sum is 64.
  localparam int SUM_GUARD = 7;

  typedef enum logic [1:0] {
    ACT_MOVE  = 2'd0,
    ACT_LINE  = 2'd1,
    ACT_QUAD  = 2'd2,
    ACT_CUBIC = 2'd3
  } action_t;

  // Step index of the final vertex of a curve (t = 1).
  localparam logic [1:0] LAST_CURVE_STEP = 2'd3;

endpackage

`default_nettype wire

>>> design/bpf_eval.sv
`default_nettype none

module bpf_eval #(
  parameter int COORD_WIDTH = bpf_pkg::COORD_WIDTH
) (
  input  wire logic                          is_cubic,
  input  wire logic [1:0]                    step,
  input  wire logic signed [COORD_WIDTH-1:0] p0,
  input  wire logic signed [COORD_WIDTH-1:0] c1,
  input  wire logic signed [COORD_WIDTH-1:0] c2,
  input  wire logic signed [COORD_WIDTH-1:0] pt,
  output logic signed [COORD_WIDTH-1:0]      point
);

  localparam int SW = COORD_WIDTH + bpf_pkg::SUM_GUARD;

  logic signed [SW-1:0] e0, e1, e2, e3;
  logic signed [SW-1:0] sum_q, sum_c;
  logic signed [SW-1:0] rnd_q, rnd_c;
  logic signed [SW-1:0] shf_q, shf_c;

  assign e0 = {{bpf_pkg::SUM_GUARD{p0[COORD_WIDTH-1]}}, p0};
  assign e1 = {{bpf_pkg::SUM_GUARD{c1[COORD_WIDTH-1]}}, c1};
  assign e2 = {{bpf_pkg::SUM_GUARD{c2[COORD_WIDTH-1]}}, c2};
  assign e3 = {{bpf_pkg::SUM_GUARD{pt[COORD_WIDTH-1]}}, pt};

  // Bernstein weights at t = 1/4, 1/2, 3/4 and 1; quadratic over 16, cubic over 64.
  always_comb begin
    case (step)
      2'd0: begin
        sum_q = SW'(9) * e0 + SW'(6) * e1 + e3;
        sum_c = SW'(27) * e0 + SW'(27) * e1 + SW'(9) * e2 + e3;
      end
      2'd1: begin
        sum_q = SW'(4) * e0 + SW'(8) * e1 + SW'(4) * e3;
        sum_c = SW'(8) * e0 + SW'(24) * e1 + SW'(24) * e2 + SW'(8) * e3;
      end
      2'd2: begin
        sum_q = e0 + SW'(6) * e1 + SW'(9) * e3;
        sum_c = e0 + SW'(9) * e1 + SW'(27) * e2 + SW'(27) * e3;
      end
      default: begin
        sum_q = SW'(16) * e3;
        sum_c = SW'(64) * e3;
      end
    endcase
  end

  // Round half up, then floor via arithmetic shift.
  assign rnd_q = sum_q + SW'(8);
  assign rnd_c = sum_c + SW'(32);
  assign shf_q = rnd_q >>> 4;
  assign shf_c = rnd_c >>> 6;

  assign point = is_cubic ? shf_c[COORD_WIDTH-1:0] : shf_q[COORD_WIDTH-1:0];

endmodule

`default_nettype wire

>>> design/bezier_path_flattener_unit.sv
// Channel   Direction  Handshake              Payload
// in_       request    in_valid / in_ready    action, ctrl1/ctrl2/target x and y
// out_      result     out_valid / out_ready  point_x, point_y, new_contour, last
//
// A move or line yields one vertex and a new request can be taken every cycle while out_ready holds.
// A curve yields four vertices, one per cycle while not stalled, from the step counter of the
// held request, and the next request is taken together with its last vertex.
// An accepted request is held first; each of its vertices then enters the output register.
// Reset (rst_n low, synchronous) empties both stages and sets the current point to zero.
// A stall on out_ready freezes the output register and the held request.
`default_nettype none

module bezier_path_flattener_unit #(
  parameter int COORD_WIDTH = bpf_pkg::COORD_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    in_action,
  input  wire logic signed [COORD_WIDTH-1:0] in_ctrl1_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_ctrl1_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_ctrl2_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_ctrl2_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_target_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_target_y,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0]      out_point_x,
  output logic signed [COORD_WIDTH-1:0]      out_point_y,
  output logic                               out_new_contour,
  output logic                               out_last
);

  logic                          hold_v_r, hold_v_nxt;
  bpf_pkg::action_t              act_r;
  logic [1:0]                    step_r, step_nxt;
  logic signed [COORD_WIDTH-1:0] c1x_r, c1y_r, c2x_r, c2y_r, tx_r, ty_r;
  logic signed [COORD_WIDTH-1:0] p0x_r, p0y_r;
  logic signed [COORD_WIDTH-1:0] cur_x_r, cur_y_r;

  logic                          ov_r, ov_nxt;
  logic signed [COORD_WIDTH-1:0] opx_r, opy_r;
  logic                          onc_r, olast_r;

  logic                          in_acc, adv, is_curve, is_cubic, last_step;
  logic signed [COORD_WIDTH-1:0] cx, cy, px, py;

  assign is_curve  = (act_r == bpf_pkg::ACT_QUAD) || (act_r == bpf_pkg::ACT_CUBIC);
  assign is_cubic  = (act_r == bpf_pkg::ACT_CUBIC);
  assign last_step = !is_curve || (step_r == bpf_pkg::LAST_CURVE_STEP);

  assign adv      = hold_v_r && (!ov_r || out_ready);
  assign in_ready = !hold_v_r || (adv && last_step);
  assign in_acc   = in_valid && in_ready;

  bpf_eval #(.COORD_WIDTH(COORD_WIDTH)) u_eval_x (
    .is_cubic (is_cubic),
    .step     (step_r),
    .p0       (p0x_r),
    .c1       (c1x_r),
    .c2       (c2x_r),
    .pt       (tx_r),
    .point    (cx)
  );

  bpf_eval #(.COORD_WIDTH(COORD_WIDTH)) u_eval_y (
    .is_cubic (is_cubic),
    .step     (step_r),
    .p0       (p0y_r),
    .c1       (c1y_r),
    .c2       (c2y_r),
    .pt       (ty_r),
    .point    (cy)
  );

  assign px = is_curve ? cx : tx_r;
  assign py = is_curve ? cy : ty_r;

  always_comb begin
    hold_v_nxt = hold_v_r;
    step_nxt   = step_r;
    if (adv) begin
      step_nxt = step_r + 2'd1;
      if (last_step) begin
        hold_v_nxt = 1'b0;
      end
    end
    if (in_acc) begin
      hold_v_nxt = 1'b1;
      step_nxt   = 2'd0;
    end
    ov_nxt = ov_r;
    if (adv) begin
      ov_nxt = 1'b1;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      step_r   <= 2'd0;
      ov_r     <= 1'b0;
      cur_x_r  <= '0;
      cur_y_r  <= '0;
    end else begin
      hold_v_r <= hold_v_nxt;
      step_r   <= step_nxt;
      ov_r     <= ov_nxt;
      if (in_acc) begin
        cur_x_r <= in_target_x;
        cur_y_r <= in_target_y;
      end
    end
  end

  // The start point of a curve is the current point at acceptance time.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r <= bpf_pkg::action_t'(in_action);
      c1x_r <= in_ctrl1_x;
      c1y_r <= in_ctrl1_y;
      c2x_r <= in_ctrl2_x;
      c2y_r <= in_ctrl2_y;
      tx_r  <= in_target_x;
      ty_r  <= in_target_y;
      p0x_r <= cur_x_r;
      p0y_r <= cur_y_r;
    end
    if (adv) begin
      opx_r   <= px;
      opy_r   <= py;
      onc_r   <= (act_r == bpf_pkg::ACT_MOVE);
      olast_r <= last_step;
    end
  end

  assign out_valid       = ov_r;
  assign out_point_x     = opx_r;
  assign out_point_y     = opy_r;
  assign out_new_contour = onc_r;
  assign out_last        = olast_r;

endmodule

`default_nettype wire

>>> design/bpf_checker.sv
`default_nettype none

module bpf_checker #(
  parameter int COORD_WIDTH = bpf_pkg::COORD_WIDTH
) (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic signed [COORD_WIDTH-1:0] out_point_x,
  input wire logic signed [COORD_WIDTH-1:0] out_point_y,
  input wire logic                          out_new_contour,
  input wire logic                          out_last
);

  // A stalled vertex stays in place with all its fields.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_point_x) &&
      $stable(out_point_y) && $stable(out_new_contour) && $stable(out_last))
    else $error("stalled vertex changed");

  // Reset empties the output register.
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("vertex presented right after reset");

  // A move yields a single vertex, so a new-contour vertex always ends its request.
  a_move_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_new_contour |-> out_last)
    else $error("new-contour vertex not marked last");

  // With nothing held after reset, the block is ready for a request.
  a_ready_after_rst: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> in_ready)
    else $error("not ready after reset");

endmodule

bind bezier_path_flattener_unit bpf_checker #(.COORD_WIDTH(COORD_WIDTH)) u_bpf_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_point_x     (out_point_x),
  .out_point_y     (out_point_y),
  .out_new_contour (out_new_contour),
  .out_last        (out_last)
);

`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int CW = bpf_pkg::COORD_WIDTH;
  localparam int STALL_LIMIT = 3000;
  localparam int LONG_HOLD = 300;

  typedef logic signed [CW-1:0] coord_t;

  localparam coord_t COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(CW-1){1'b0}}};

  typedef struct {
    coord_t x;
    coord_t y;
    logic   new_contour;
    logic   last;
  } vertex_t;

  // Tracks the pen position and the vertices each accepted command must produce.
  class vertex_scoreboard;
    vertex_t expected_vertices[$];
    coord_t  pen_x;
    coord_t  pen_y;
    int      errors;

    function new();
      pen_x = '0;
      pen_y = '0;
      errors = 0;
    endfunction

    // Uniform samples at t = k/4, rounded half up with an arithmetic shift.
    function longint blend(bpf_pkg::action_t act, int k, longint p0, longint c1,
                           longint c2, longint p3);
      longint a;
      longint b;
      a = 4 - k;
      b = k;
      if (act == bpf_pkg::ACT_QUAD)
        return (a*a*p0 + 2*a*b*c1 + b*b*p3 + 8) >>> 4;
      return (a*a*a*p0 + 3*a*a*b*c1 + 3*a*b*b*c2 + b*b*b*p3 + 32) >>> 6;
    endfunction

    function void flatten_command(bpf_pkg::action_t act, coord_t c1x, coord_t c1y,
                                  coord_t c2x, coord_t c2y, coord_t tx, coord_t ty);
      vertex_t v;
      if (act == bpf_pkg::ACT_MOVE || act == bpf_pkg::ACT_LINE) begin
        v.x = tx;
        v.y = ty;
        v.new_contour = (act == bpf_pkg::ACT_MOVE);
        v.last = 1'b1;
        expected_vertices.push_back(v);
      end else begin
        for (int k = 1; k <= 4; k++) begin
          v.x = coord_t'(blend(act, k, longint'(pen_x), longint'(c1x), longint'(c2x),
                               longint'(tx)));
          v.y = coord_t'(blend(act, k, longint'(pen_y), longint'(c1y), longint'(c2y),
                               longint'(ty)));
          v.new_contour = 1'b0;
          v.last = (k == 4);
          expected_vertices.push_back(v);
        end
      end
      pen_x = tx;
      pen_y = ty;
    endfunction

    function void check_vertex(coord_t px, coord_t py, logic nc, logic lst);
      vertex_t want;
      if (expected_vertices.size() == 0) begin
        $error("vertex (%0d, %0d) arrived with nothing expected", px, py);
        errors++;
        return;
      end
      want = expected_vertices.pop_front();
      if (px !== want.x) begin
        $error("point_x: expected %0d, got %0d", want.x, px);
        errors++;
      end
      if (py !== want.y) begin
        $error("point_y: expected %0d, got %0d", want.y, py);
        errors++;
      end
      if (nc !== want.new_contour) begin
        $error("new_contour: expected %0b, got %0b", want.new_contour, nc);
        errors++;
      end
      if (lst !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, lst);
        errors++;
      end
    endfunction

    function int outstanding();
      return expected_vertices.size();
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  bpf_pkg::action_t in_action;
  coord_t           in_ctrl1_x;
  coord_t           in_ctrl1_y;
  coord_t           in_ctrl2_x;
  coord_t           in_ctrl2_y;
  coord_t           in_target_x;
  coord_t           in_target_y;
  logic             out_valid;
  logic             out_ready;
  coord_t           out_point_x;
  coord_t           out_point_y;
  logic             out_new_contour;
  logic             out_last;

  bit in_idle_on = 1'b1;
  bit out_idle_on = 1'b1;
  int hold_cycles = 0;
  int stall_cycles = 0;

  vertex_scoreboard sb = new();

  bezier_path_flattener_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_ctrl1_x      (in_ctrl1_x),
    .in_ctrl1_y      (in_ctrl1_y),
    .in_ctrl2_x      (in_ctrl2_x),
    .in_ctrl2_y      (in_ctrl2_y),
    .in_target_x     (in_target_x),
    .in_target_y     (in_target_y),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_point_x     (out_point_x),
    .out_point_y     (out_point_y),
    .out_new_contour (out_new_contour),
    .out_last        (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Handshake monitor and no-progress watchdog.
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_cycles <= 0;
    end else begin
      if (in_valid && in_ready)
        sb.flatten_command(in_action, in_ctrl1_x, in_ctrl1_y, in_ctrl2_x, in_ctrl2_y,
                           in_target_x, in_target_y);
      if (out_valid && out_ready)
        sb.check_vertex(out_point_x, out_point_y, out_new_contour, out_last);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT) begin
        $display("bezier_path_flattener_unit regression: fail");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Vertex sink: random back-pressure per vertex, plus an optional long hold-off.
  initial begin : vertex_sink
    int n;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      n = out_idle_on ? $urandom_range(0, 15) : 0;
      @(negedge clk);
      if (hold_cycles != 0) begin
        out_ready = 1'b0;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
      end
      if (n != 0) begin
        out_ready = 1'b0;
        repeat (n) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 7))
      0: return COORD_MAX;
      1: return COORD_MIN;
      2: return coord_t'(0);
      3: return coord_t'(-1);
      4, 5: return coord_t'($urandom_range(0, 1023) - 512);
      default: return coord_t'($urandom);
    endcase
  endfunction

  task automatic send_command(input bpf_pkg::action_t act, input coord_t c1x,
                              input coord_t c1y, input coord_t c2x, input coord_t c2y,
                              input coord_t tx, input coord_t ty);
    int gap;
    gap = in_idle_on ? $urandom_range(0, 15) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_action = act;
    in_ctrl1_x = c1x;
    in_ctrl1_y = c1y;
    in_ctrl2_x = c2x;
    in_ctrl2_y = c2y;
    in_target_x = tx;
    in_target_y = ty;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // Mostly well-formed contours (a move, then segments); now and then a stray command.
  task automatic send_random_commands(input int count);
    int seg_left;
    seg_left = 0;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_command(bpf_pkg::action_t'($urandom_range(0, 3)), rand_coord(), rand_coord(),
                     rand_coord(), rand_coord(), rand_coord(), rand_coord());
      end else if (seg_left == 0) begin
        send_command(bpf_pkg::ACT_MOVE, rand_coord(), rand_coord(), rand_coord(),
                     rand_coord(), rand_coord(), rand_coord());
        seg_left = $urandom_range(1, 6);
      end else begin
        send_command(bpf_pkg::action_t'($urandom_range(1, 3)), rand_coord(), rand_coord(),
                     rand_coord(), rand_coord(), rand_coord(), rand_coord());
        seg_left--;
      end
    end
  endtask

  // The last request has already been taken, so valid drops before waiting.
  task automatic wait_for_drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = bpf_pkg::ACT_MOVE;
    in_ctrl1_x = '0;
    in_ctrl1_y = '0;
    in_ctrl2_x = '0;
    in_ctrl2_y = '0;
    in_target_x = '0;
    in_target_y = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Curve straight out of reset starts from the origin.
    send_command(bpf_pkg::ACT_QUAD, 24'sd100, -24'sd100, 24'sd77, -24'sd77, 24'sd200,
                 24'sd300);
    // Line with no move before it, controls ignored.
    send_command(bpf_pkg::ACT_LINE, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX,
                 COORD_MIN);
    send_command(bpf_pkg::ACT_MOVE, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN,
                 COORD_MIN);
    send_command(bpf_pkg::ACT_CUBIC, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                 COORD_MAX);
    send_command(bpf_pkg::ACT_CUBIC, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                 COORD_MIN);
    // Quadratic with a second control that must have no effect.
    send_command(bpf_pkg::ACT_QUAD, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX,
                 COORD_MAX);
    send_command(bpf_pkg::ACT_MOVE, '0, '0, '0, '0, '0, '0);
    // Small sums around zero exercise rounding half up on both signs.
    send_command(bpf_pkg::ACT_QUAD, 24'sd1, -24'sd1, '0, '0, '0, '0);
    send_command(bpf_pkg::ACT_CUBIC, -24'sd1, -24'sd3, 24'sd5, -24'sd7, -24'sd2, 24'sd2);
    send_command(bpf_pkg::ACT_CUBIC, 24'sd32, -24'sd32, -24'sd32, 24'sd32, 24'sd1,
                 -24'sd1);
    send_command(bpf_pkg::ACT_MOVE, -24'sd1, -24'sd1, 24'sd9, 24'sd9, -24'sd1, -24'sd1);
    send_command(bpf_pkg::ACT_LINE, '0, '0, '0, '0, 24'sd1, 24'sd1);
    send_command(bpf_pkg::ACT_QUAD, COORD_MIN, COORD_MAX, '0, '0, COORD_MAX, COORD_MIN);
    send_command(bpf_pkg::ACT_CUBIC, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN,
                 COORD_MAX);

    // Sender pause until the block is empty, then a long sink hold-off under a full feed.
    wait_for_drain();
    hold_cycles = LONG_HOLD;
    in_idle_on = 1'b0;
    send_random_commands(24);

    in_idle_on = 1'b1;
    out_idle_on = 1'b1;
    send_random_commands(20);
    wait_for_drain();
    in_idle_on = 1'b0;
    out_idle_on = 1'b0;
    send_random_commands(20);
    in_idle_on = 1'b1;
    out_idle_on = 1'b0;
    send_random_commands(20);
    in_idle_on = 1'b0;
    out_idle_on = 1'b1;
    send_random_commands(20);

    @(negedge clk);
    in_valid = 1'b0;
    wait_for_drain();
    repeat (20) @(posedge clk);
    if (sb.outstanding() != 0) begin
      $error("%0d vertices still expected at the end", sb.outstanding());
      sb.errors++;
    end
    if (sb.errors == 0)
      $display("bezier_path_flattener_unit regression: pass");
    else
      $display("bezier_path_flattener_unit regression: fail");
    $finish;
  end

endmodule
